// ===== hw/rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGES     = 4096;
  localparam int TOP_ORDER = 10;
  localparam int AW        = 12;             // page address width
  localparam int LW        = 13;             // link width, holds NIL
  localparam int OW        = 4;              // order width
  localparam logic [LW-1:0] NIL = LW'(PAGES);

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_TOTAL_PAGES = 1'b0;   // register index bit of paddr

  // one entry per page
  typedef struct packed {
    logic          hf;     // page heads a free block
    logic [OW-1:0] ord;    // order of that block
    logic [LW-1:0] nx;     // next in free list
    logic [LW-1:0] pv;     // previous in free list
  } ent_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ALLOC, S_ALLOC_RD, S_FREE, S_FSCAN, S_FDRAIN,
    S_MNEXT, S_MCHK, S_UL_W, S_UL_PVW, S_UL_NX, S_UL_NXW, S_SPLIT,
    S_PUSH_W, S_PUSH_HW, S_OUT
  } state_t;

endpackage

// ===== hw/rtl/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy page allocator, orders 0 to 10, per-page state in one RAM.
// ----------------------------------------------------------------------------
// Steps: an allocate finds the list, reads its head, unlinks it, pushes
//   one upper half per split level and gives its result; a free runs the
//   overlap scan, then checks and unlinks one buddy per merge, and ends in a
//   last check, push and result; a rejected item goes to its result. One RAM.
// Throughput: one item at a time; the next item is taken once the result
//   sits in the output register.
// Reset and every total_pages write start a pass that rewrites every page
//   entry and carves the free lists; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [12:0] page_count,
  input  logic [11:0] block_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] result_block,
  output logic [10:0] block_pages,
  output logic [12:0] free_total
);

  localparam int AW = bpa_pkg::AW;
  localparam int LW = bpa_pkg::LW;
  localparam int OW = bpa_pkg::OW;
  localparam int TO = bpa_pkg::TOP_ORDER;

  bpa_pkg::state_t state, state_next;

  // configuration and list heads
  logic [12:0]   total_pages;
  logic [12:0]   managed;
  logic [LW-1:0] head [TO+1];
  logic [12:0]   free_cnt;

  // latched request
  logic          q_cmd;
  logic [AW-1:0] q_base;
  logic [OW-1:0] q_req;
  logic          q_ok;

  // working registers
  logic [AW-1:0] cur, tgt, pp, h_reg;
  logic [OW-1:0] o;
  bpa_pkg::ent_t ent;

  // overlap scan
  logic [10:0]   j;
  logic          sphase;
  logic [OW-1:0] so;
  logic          chk_v, chk_any, ovl;
  logic [OW-1:0] chk_ord;

  // carve pass
  logic [12:0]   ca, ccur, crem;
  logic [OW-1:0] corder;
  logic [12:0]   csize;
  logic [LW-1:0] cprev;

  // result staging
  logic [1:0]    r_status;
  logic [AW-1:0] r_blk;
  logic [10:0]   r_pages;

  // RAM port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  bpa_pkg::ent_t wdata, rd;
  logic [$bits(bpa_pkg::ent_t)-1:0] rdata_raw;

  assign rd = bpa_pkg::ent_t'(rdata_raw);

  bpa_ram #(
    .WIDTH ($bits(bpa_pkg::ent_t)),
    .DEPTH (bpa_pkg::PAGES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  logic        cfg_we;
  logic [12:0] new_managed;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == bpa_pkg::REG_TOTAL_PAGES);
  assign new_managed = (pwdata[12:0] > 13'(bpa_pkg::PAGES)) ?
                       13'(bpa_pkg::PAGES) : pwdata[12:0];
  assign prdata = (paddr[2] == bpa_pkg::REG_TOTAL_PAGES) ?
                  {19'b0, total_pages} : 32'b0;

  assign managed = (total_pages > 13'(bpa_pkg::PAGES)) ?
                   13'(bpa_pkg::PAGES) : total_pages;

  // ------------------------------------------------------------------
  // Request decode: rounded order and size
  // ------------------------------------------------------------------
  logic [OW-1:0] in_req;
  logic          in_ok;
  logic [10:0]   size;
  logic [12:0]   size13;

  always_comb begin
    in_req = '0;
    for (int i = TO; i >= 0; i--) begin
      if ((13'(1) << i) >= page_count) begin
        in_req = OW'(i);
      end
    end
  end

  assign in_ok  = (page_count != 13'd0) && (page_count <= (13'(1) << TO));
  assign size   = 11'(1) << q_req;
  assign size13 = {2'b0, size};

  // first non-empty order at or above the request
  logic          found;
  logic [OW-1:0] fo;

  always_comb begin
    found = 1'b0;
    fo    = '0;
    for (int i = TO; i >= 0; i--) begin
      if ((OW'(i) >= q_req) && (head[i] != bpa_pkg::NIL)) begin
        found = 1'b1;
        fo    = OW'(i);
      end
    end
  end

  // free request address checks (overlap checked by the scan)
  logic fvalid;
  assign fvalid = q_ok && ({1'b0, q_base} < managed) &&
                  ((q_base & (AW'(size) - AW'(1))) == '0) &&
                  (({1'b0, q_base} + size13) <= managed);

  // overlap scan hit on the data returning this cycle
  logic hit;
  assign hit = chk_v && rd.hf && (chk_any || (rd.ord == chk_ord));

  // buddy of the block under merge
  logic [AW-1:0] bud;
  logic          can_merge, bud_match;
  assign bud       = cur ^ (AW'(1) << o);
  assign can_merge = (o < OW'(TO)) && ({1'b0, bud} < managed);
  assign bud_match = rd.hf && (rd.ord == o);

  // carve: largest block that fits the remainder
  always_comb begin
    corder = '0;
    if (crem >= (13'(1) << TO)) begin
      corder = OW'(TO);
    end else begin
      for (int i = 0; i < TO; i++) begin
        if (crem[i]) begin
          corder = OW'(i);
        end
      end
    end
  end

  assign csize = 13'(1) << corder;
  // only top-order blocks can share a list during the carve
  assign cprev = ((corder == OW'(TO)) && ((crem - csize) >= csize)) ?
                 LW'(ccur + csize) : bpa_pkg::NIL;

  logic ul_done, push_done;
  assign ul_done   = ((state == bpa_pkg::S_UL_NX) && (ent.nx == bpa_pkg::NIL)) ||
                     (state == bpa_pkg::S_UL_NXW);
  assign push_done = ((state == bpa_pkg::S_PUSH_W) && (head[o] == bpa_pkg::NIL)) ||
                     (state == bpa_pkg::S_PUSH_HW);

  assign in_stall = (state != bpa_pkg::S_IDLE);

  // ------------------------------------------------------------------
  // Next state and RAM control
  // ------------------------------------------------------------------
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (state)
      bpa_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = ca[AW-1:0];
        if ((crem != '0) && (ca == ccur)) begin
          wdata = '{hf: 1'b1, ord: corder, nx: head[corder], pv: cprev};
        end
        if (ca == 13'(bpa_pkg::PAGES - 1)) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (command == bpa_pkg::CMD_FREE) ? bpa_pkg::S_FREE :
                                                        bpa_pkg::S_ALLOC;
        end
      end
      bpa_pkg::S_ALLOC: begin
        if (q_ok && found) begin
          re         = 1'b1;
          raddr      = head[fo][AW-1:0];
          state_next = bpa_pkg::S_ALLOC_RD;
        end else begin
          state_next = bpa_pkg::S_OUT;
        end
      end
      bpa_pkg::S_ALLOC_RD: state_next = bpa_pkg::S_UL_W;
      bpa_pkg::S_UL_W: begin
        we    = 1'b1;
        waddr = tgt;
        wdata = '{hf: 1'b0, ord: ent.ord, nx: ent.nx, pv: ent.pv};
        if (ent.pv != bpa_pkg::NIL) begin
          re         = 1'b1;
          raddr      = ent.pv[AW-1:0];
          state_next = bpa_pkg::S_UL_PVW;
        end else begin
          state_next = bpa_pkg::S_UL_NX;
        end
      end
      bpa_pkg::S_UL_PVW: begin
        we       = 1'b1;
        waddr    = ent.pv[AW-1:0];
        wdata    = rd;
        wdata.nx = ent.nx;
        state_next = bpa_pkg::S_UL_NX;
      end
      bpa_pkg::S_UL_NX: begin
        if (ent.nx != bpa_pkg::NIL) begin
          re         = 1'b1;
          raddr      = ent.nx[AW-1:0];
          state_next = bpa_pkg::S_UL_NXW;
        end else begin
          state_next = (q_cmd == bpa_pkg::CMD_FREE) ? bpa_pkg::S_MNEXT :
                                                      bpa_pkg::S_SPLIT;
        end
      end
      bpa_pkg::S_UL_NXW: begin
        we       = 1'b1;
        waddr    = ent.nx[AW-1:0];
        wdata    = rd;
        wdata.pv = ent.pv;
        state_next = (q_cmd == bpa_pkg::CMD_FREE) ? bpa_pkg::S_MNEXT :
                                                    bpa_pkg::S_SPLIT;
      end
      bpa_pkg::S_SPLIT: begin
        state_next = (o > q_req) ? bpa_pkg::S_PUSH_W : bpa_pkg::S_OUT;
      end
      bpa_pkg::S_PUSH_W: begin
        we    = 1'b1;
        waddr = pp;
        wdata = '{hf: 1'b1, ord: o, nx: head[o], pv: bpa_pkg::NIL};
        if (head[o] != bpa_pkg::NIL) begin
          re         = 1'b1;
          raddr      = head[o][AW-1:0];
          state_next = bpa_pkg::S_PUSH_HW;
        end else begin
          state_next = (q_cmd == bpa_pkg::CMD_FREE) ? bpa_pkg::S_OUT :
                                                      bpa_pkg::S_SPLIT;
        end
      end
      bpa_pkg::S_PUSH_HW: begin
        we       = 1'b1;
        waddr    = h_reg;
        wdata    = rd;
        wdata.pv = {1'b0, pp};
        state_next = (q_cmd == bpa_pkg::CMD_FREE) ? bpa_pkg::S_OUT :
                                                    bpa_pkg::S_SPLIT;
      end
      bpa_pkg::S_FREE: begin
        state_next = fvalid ? bpa_pkg::S_FSCAN : bpa_pkg::S_OUT;
      end
      bpa_pkg::S_FSCAN: begin
        re = 1'b1;
        if (sphase) begin
          raddr = q_base & ~((AW'(1) << so) - AW'(1));
          if (so == OW'(TO)) begin
            state_next = bpa_pkg::S_FDRAIN;
          end
        end else begin
          raddr = AW'(q_base + AW'(j));
          if ((j == size - 11'd1) && (q_req == OW'(TO))) begin
            state_next = bpa_pkg::S_FDRAIN;
          end
        end
      end
      bpa_pkg::S_FDRAIN: begin
        state_next = (ovl || hit) ? bpa_pkg::S_OUT : bpa_pkg::S_MNEXT;
      end
      bpa_pkg::S_MNEXT: begin
        if (can_merge) begin
          re         = 1'b1;
          raddr      = bud;
          state_next = bpa_pkg::S_MCHK;
        end else begin
          state_next = bpa_pkg::S_PUSH_W;
        end
      end
      bpa_pkg::S_MCHK: begin
        state_next = bud_match ? bpa_pkg::S_UL_W : bpa_pkg::S_PUSH_W;
      end
      bpa_pkg::S_OUT: begin
        if (!(out_valid && out_stall)) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      default: state_next = bpa_pkg::S_IDLE;
    endcase
    if (cfg_we) begin
      state_next = bpa_pkg::S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------------------------------
  // Datapath registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= 13'(bpa_pkg::PAGES);
      free_cnt    <= 13'(bpa_pkg::PAGES);
      crem        <= 13'(bpa_pkg::PAGES);
      ca          <= '0;
      ccur        <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i <= TO; i++) begin
        head[i] <= bpa_pkg::NIL;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        bpa_pkg::S_CLEAR: begin
          if ((crem != '0) && (ca == ccur)) begin
            head[corder] <= LW'(ca);
            ccur         <= ccur + csize;
            crem         <= crem - csize;
          end
          ca <= ca + 13'd1;
        end
        bpa_pkg::S_IDLE: begin
          if (in_valid) begin
            q_cmd  <= command;
            q_base <= block_index;
            q_req  <= in_req;
            q_ok   <= in_ok;
          end
        end
        bpa_pkg::S_ALLOC: begin
          if (q_ok && found) begin
            o   <= fo;
            tgt <= head[fo][AW-1:0];
            cur <= head[fo][AW-1:0];
          end else begin
            r_status <= q_ok ? bpa_pkg::ST_OOM : bpa_pkg::ST_BAD;
            r_blk    <= '0;
            r_pages  <= '0;
          end
        end
        bpa_pkg::S_ALLOC_RD: ent <= rd;
        bpa_pkg::S_UL_W: begin
          if (ent.pv == bpa_pkg::NIL) begin
            head[o] <= ent.nx;
          end
        end
        bpa_pkg::S_SPLIT: begin
          if (o > q_req) begin
            o  <= o - OW'(1);
            pp <= cur + (AW'(1) << (o - OW'(1)));
          end else begin
            r_status <= bpa_pkg::ST_OK;
            r_blk    <= cur;
            r_pages  <= size;
            free_cnt <= free_cnt - size13;
          end
        end
        bpa_pkg::S_PUSH_W: begin
          head[o] <= {1'b0, pp};
          h_reg   <= head[o][AW-1:0];
        end
        bpa_pkg::S_FREE: begin
          j      <= '0;
          sphase <= 1'b0;
          so     <= q_req + OW'(1);
          ovl    <= 1'b0;
          chk_v  <= 1'b0;
          if (!fvalid) begin
            r_status <= bpa_pkg::ST_BAD;
            r_blk    <= '0;
            r_pages  <= '0;
          end
        end
        bpa_pkg::S_FSCAN: begin
          chk_v   <= 1'b1;
          chk_any <= !sphase;
          chk_ord <= so;
          if (hit) begin
            ovl <= 1'b1;
          end
          if (sphase) begin
            so <= so + OW'(1);
          end else if (j == size - 11'd1) begin
            sphase <= 1'b1;
          end else begin
            j <= j + 11'd1;
          end
        end
        bpa_pkg::S_FDRAIN: begin
          if (ovl || hit) begin
            r_status <= bpa_pkg::ST_BAD;
            r_blk    <= '0;
            r_pages  <= '0;
          end else begin
            cur <= q_base;
            o   <= q_req;
          end
        end
        bpa_pkg::S_MNEXT: begin
          if (!can_merge) begin
            pp <= cur;
          end
        end
        bpa_pkg::S_MCHK: begin
          if (bud_match) begin
            ent <= rd;
            tgt <= bud;
          end else begin
            pp <= cur;
          end
        end
        bpa_pkg::S_OUT: begin
          if (!(out_valid && out_stall)) begin
            out_valid    <= 1'b1;
            status       <= r_status;
            result_block <= r_blk;
            block_pages  <= r_pages;
            free_total   <= free_cnt;
          end
        end
        default: ;
      endcase

      // merged buddy gone: carry on one order up from the lower half
      if (ul_done && (q_cmd == bpa_pkg::CMD_FREE)) begin
        cur <= (tgt < cur) ? tgt : cur;
        o   <= o + OW'(1);
      end
      // free finishes with its push
      if (push_done && (q_cmd == bpa_pkg::CMD_FREE)) begin
        r_status <= bpa_pkg::ST_OK;
        r_blk    <= pp;
        r_pages  <= 11'(1) << o;
        free_cnt <= free_cnt + size13;
      end

      // rebuild on a page-count write
      if (cfg_we) begin
        total_pages <= pwdata[12:0];
        free_cnt    <= new_managed;
        crem        <= new_managed;
        ca          <= '0;
        ccur        <= '0;
        for (int i = 0; i <= TO; i++) begin
          head[i] <= bpa_pkg::NIL;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::S_IDLE) |-> (free_cnt <= managed))
    else $error("free count above managed pages");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == bpa_pkg::S_OUT))
    else $error("result loaded outside output state");

  a_ok_pow2: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == bpa_pkg::ST_OK)) |-> $onehot(block_pages))
    else $error("ok result with bad block size");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != bpa_pkg::ST_OK)) |->
      ((result_block == '0) && (block_pages == '0)))
    else $error("failed result carries a block");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buddy page allocator. A queue of pending
// requests feeds a clocked driver. A built-in allocator predicts the result
// of each accepted request. A clocked monitor compares every result, field by
// field, with the oldest prediction. The run covers several page-count
// settings, directed corner requests and random alloc/free traffic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT = 4_000_000;
  localparam logic [2:0] ADDR_TOTAL_PAGES = 3'd0;

  typedef struct {
    logic        cmd;
    logic [12:0] n;
    logic [11:0] idx;
  } req_t;

  typedef struct {
    logic [1:0]  st;
    logic [11:0] blk;
    logic [10:0] pg;
    logic [12:0] ft;
  } res_t;

  typedef struct {
    int base;
    int n;
  } held_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = bpa_pkg::CMD_ALLOC;
  logic [12:0] page_count = '0;
  logic [11:0] block_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [11:0] result_block;
  logic [10:0] block_pages;
  logic [12:0] free_total;

  buddy_page_allocator u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: its own copy of the per-page state and free lists
  // --------------------------------------------------------------------------
  logic       pg_head_free [bpa_pkg::PAGES];
  logic [3:0] pg_order     [bpa_pkg::PAGES];
  int         pg_next      [bpa_pkg::PAGES];
  int         pg_prev      [bpa_pkg::PAGES];
  int         list_head    [bpa_pkg::TOP_ORDER+1];
  int         pred_free;
  int         managed_pages;

  function automatic void push_free(int o, int p);
    int h;
    h = list_head[o];
    pg_next[p] = h;
    pg_prev[p] = bpa_pkg::PAGES;
    if (h != bpa_pkg::PAGES) pg_prev[h] = p;
    list_head[o] = p;
    pg_head_free[p] = 1'b1;
    pg_order[p] = 4'(o);
  endfunction

  function automatic void unlink_free(int o, int p);
    int nx, pv;
    nx = pg_next[p];
    pv = pg_prev[p];
    if (pv != bpa_pkg::PAGES) pg_next[pv] = nx;
    else list_head[o] = nx;
    if (nx != bpa_pkg::PAGES) pg_prev[nx] = pv;
    pg_head_free[p] = 1'b0;
  endfunction

  // greedy carve from page 0 upward into the largest blocks that fit
  function automatic void carve_pages(int total);
    int o, cur, rem;
    managed_pages = total > bpa_pkg::PAGES ? bpa_pkg::PAGES : total;
    for (int i = 0; i < bpa_pkg::PAGES; i++) begin
      pg_head_free[i] = 1'b0;
      pg_order[i] = '0;
    end
    for (int i = 0; i <= bpa_pkg::TOP_ORDER; i++) list_head[i] = bpa_pkg::PAGES;
    pred_free = managed_pages;
    rem = managed_pages;
    cur = 0;
    o = bpa_pkg::TOP_ORDER;
    while (rem > 0) begin
      if ((1 << o) <= rem) begin
        push_free(o, cur);
        cur += 1 << o;
        rem -= 1 << o;
      end else begin
        o--;
      end
    end
  endfunction

  // double free: any free block containing base, or any free head inside it
  function automatic bit hits_free(int base, int sz);
    int s;
    for (int o = 0; o <= bpa_pkg::TOP_ORDER; o++) begin
      s = base & ~((1 << o) - 1);
      if (pg_head_free[s] && pg_order[s] == o) return 1'b1;
    end
    for (int p = base; p < base + sz; p++)
      if (pg_head_free[p]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t serve_request(logic cmd, logic [12:0] n, logic [11:0] idx);
    int   req, sz, o, p, cur, b, base;
    res_t r;
    r = '{bpa_pkg::ST_BAD, '0, '0, '0};
    base = int'(idx);
    if (n >= 1 && n <= (1 << bpa_pkg::TOP_ORDER)) begin
      req = 0;
      while ((1 << req) < n) req++;
      sz = 1 << req;
      if (cmd == bpa_pkg::CMD_ALLOC) begin
        r.st = bpa_pkg::ST_OOM;
        o = req;
        while (o <= bpa_pkg::TOP_ORDER && list_head[o] == bpa_pkg::PAGES) o++;
        if (o <= bpa_pkg::TOP_ORDER) begin
          p = list_head[o];
          unlink_free(o, p);
          while (o > req) begin
            o--;
            push_free(o, p + (1 << o));
          end
          pg_order[p] = 4'(req);
          pred_free -= sz;
          r = '{bpa_pkg::ST_OK, 12'(p), 11'(sz), '0};
        end
      end else if (base < managed_pages && (base & (sz - 1)) == 0 &&
                   base + sz <= managed_pages && !hits_free(base, sz)) begin
        cur = base;
        o = req;
        // merge upward while the buddy is a free block of the same order
        while (o < bpa_pkg::TOP_ORDER) begin
          b = cur ^ (1 << o);
          if (b < managed_pages && pg_head_free[b] && pg_order[b] == o) begin
            unlink_free(o, b);
            if (b < cur) cur = b;
            o++;
          end else begin
            break;
          end
        end
        push_free(o, cur);
        pred_free += sz;
        r = '{bpa_pkg::ST_OK, 12'(cur), 11'(1 << o), '0};
      end
    end
    r.ft = 13'(pred_free);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  req_t  pending_q [$];
  res_t  expected_q [$];
  held_t held_q [$];        // blocks handed out and not yet returned
  int    fails = 0;
  int    n_alloc_ok = 0, n_free_ok = 0, n_oom = 0, n_bad = 0, n_checked = 0;
  bit    calm = 1'b0;       // no idling in the last part of the run
  bit    long_hold = 1'b0;
  int    send_idle = 0;
  int    recv_idle = 0;
  int    cycles = 0;
  req_t  cur_item;
  res_t  pred;

  // --------------------------------------------------------------------------
  // Driver: predicts on each accepted item, then loads the next or idles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = serve_request(command, page_count, block_index);
        expected_q.push_back(pred);
        if (pred.st == bpa_pkg::ST_OK && command == bpa_pkg::CMD_ALLOC)
          held_q.push_back('{int'(pred.blk), int'(page_count)});
        if (pred.st == bpa_pkg::ST_OK && command == bpa_pkg::CMD_ALLOC) n_alloc_ok++;
        else if (pred.st == bpa_pkg::ST_OK) n_free_ok++;
        else if (pred.st == bpa_pkg::ST_OOM) n_oom++;
        else n_bad++;
      end
      if (!in_valid || !in_stall) begin
        if (send_idle > 0) begin
          send_idle--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_idle = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          in_valid    <= 1'b1;
          command     <= cur_item.cmd;
          page_count  <= cur_item.n;
          block_index <= cur_item.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result, drives the result stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: st=%0d blk=%0d pg=%0d ft=%0d",
                   $time, status, result_block, block_pages, free_total);
          fails++;
        end else begin
          pred = expected_q.pop_front();
          n_checked++;
          if (status !== pred.st) begin
            $display("%0t: status exp %0d got %0d", $time, pred.st, status);
            fails++;
          end
          if (result_block !== pred.blk) begin
            $display("%0t: result_block exp %0d got %0d", $time, pred.blk, result_block);
            fails++;
          end
          if (block_pages !== pred.pg) begin
            $display("%0t: block_pages exp %0d got %0d", $time, pred.pg, block_pages);
            fails++;
          end
          if (free_total !== pred.ft) begin
            $display("%0t: free_total exp %0d got %0d", $time, pred.ft, free_total);
            fails++;
          end
        end
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (recv_idle > 0) begin
        recv_idle--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_idle = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_item(logic cmd, int n, int idx);
    pending_q.push_back('{cmd, 13'(n), 12'(idx)});
  endtask

  task automatic wait_sent();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // wait until every item is sent and every expected result is in
  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  // write total_pages while idle; the predictor rebuilds at the same edge
  task automatic write_total(int v);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_TOTAL_PAGES; pwdata <= 32'(v & 13'h1fff);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    carve_pages(v & 13'h1fff);
    held_q.delete();
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // mostly small requests, now and then a large one
  function automatic int pick_size();
    if ($urandom_range(0, 19) == 0) return $urandom_range(65, 1 << bpa_pkg::TOP_ORDER);
    if ($urandom_range(0, 3) == 0) return $urandom_range(9, 64);
    return $urandom_range(1, 8);
  endfunction

  task automatic random_items(int count);
    int    r, k, sz;
    held_t h;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        add_item(bpa_pkg::CMD_ALLOC, pick_size(), $urandom_range(0, 4095));
      end else if (r < 82 && held_q.size() > 0) begin
        // return a held block, sometimes with another count of the same rounding
        k = $urandom_range(0, held_q.size() - 1);
        h = held_q[k];
        held_q.delete(k);
        sz = h.n;
        if ($urandom_range(0, 3) == 0) begin
          sz = 1;
          while (sz < h.n) sz <<= 1;
          sz = $urandom_range(sz / 2 + 1, sz);
        end
        add_item(bpa_pkg::CMD_FREE, sz, h.base);
      end else if (r < 92) begin
        // aligned free that is likely stale or double
        sz = 1 << $urandom_range(0, 6);
        add_item(bpa_pkg::CMD_FREE, sz, $urandom_range(0, 4095) & ~(sz - 1));
      end else begin
        add_item(1'($urandom_range(0, 1)), $urandom_range(0, 4096),
                 $urandom_range(0, 4095));
      end
      if (i % 8 == 7) wait_sent();
    end
    wait_sent();
  endtask

  held_t hb;

  initial begin
    carve_pages(4096);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed corners on the full reset setting
    add_item(bpa_pkg::CMD_ALLOC, 1, 0);
    add_item(bpa_pkg::CMD_ALLOC, 3, 4095);
    add_item(bpa_pkg::CMD_ALLOC, 1 << bpa_pkg::TOP_ORDER, 0);
    add_item(bpa_pkg::CMD_ALLOC, 0, 0);
    add_item(bpa_pkg::CMD_ALLOC, (1 << bpa_pkg::TOP_ORDER) + 1, 0);
    add_item(bpa_pkg::CMD_ALLOC, 4096, 4095);
    for (int i = 0; i < 4; i++) add_item(bpa_pkg::CMD_ALLOC, 1 << bpa_pkg::TOP_ORDER, 0);
    add_item(bpa_pkg::CMD_ALLOC, 1, 0);
    drain();
    while (held_q.size() > 0) begin
      hb = held_q.pop_back();
      add_item(bpa_pkg::CMD_FREE, hb.n, hb.base);
    end
    add_item(bpa_pkg::CMD_FREE, 1, 0);         // double free
    add_item(bpa_pkg::CMD_FREE, 2, 1);         // misaligned
    add_item(bpa_pkg::CMD_FREE, 8, 4095);      // misaligned near the top
    add_item(bpa_pkg::CMD_FREE, 0, 0);         // bad size
    add_item(bpa_pkg::CMD_FREE, 4096, 0);      // oversize
    drain();

    random_items(130);

    // receiver holds off long while the sender keeps offering
    long_hold <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    random_items(6);

    write_total(1);
    add_item(bpa_pkg::CMD_ALLOC, 2, 0);
    add_item(bpa_pkg::CMD_FREE, 1, 1);         // past the managed pages
    random_items(20);
    write_total(0);
    random_items(15);
    write_total(8191);                // above the page count, caps at full size
    random_items(100);
    write_total($urandom_range(700, 3000));
    random_items(120);
    write_total(37);
    random_items(60);
    write_total(4096);
    random_items(60);
    calm = 1'b1;
    random_items(90);

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d results: %0d allocs, %0d frees, %0d out of memory, %0d rejected",
             n_checked, n_alloc_ok, n_free_ok, n_oom, n_bad);
    $display("page-count settings 4096, 1, 0, 8191, mid, 37 and 4096 again");
    if (fails == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/buddy_page_allocator.sv
verif/testbench.sv
